FILE: rtl/core/ikht_pkg.sv
`default_nettype none
package ikht_pkg;

   // Table geometry; the response field widths are sized for these values.
   localparam int BUCKETS = 64;
   localparam int NODES = 256;

   typedef enum logic [2:0] {
      KIND_FIND    = 3'd0,
      KIND_ADD     = 3'd1,
      KIND_DELETE  = 3'd2,
      KIND_REPLACE = 3'd3,
      KIND_FLUSH   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_NULL_DATA = 3'd3,
      ST_POOL_FULL = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] key;
      logic [31:0]        data_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] data_out;
      logic [8:0]  entry_count;
      logic [31:0] delete_count;
      logic [6:0]  empty_buckets;
      logic [31:0] scan_count;
      logic [31:0] hit_count;
      logic [31:0] check_count;
      logic [8:0]  longest_scan;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_HEAD,
      S_READ,
      S_CMP,
      S_FREE,
      S_ALLOC,
      S_UNLINK,
      S_REPL,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/core/integer_key_chained_hash_table_unit.sv
`default_nettype none
// Integer-key chained hash table.
// Request channel: an operation (find, add, delete, replace, flush) with key
// and data is taken when start is high and busy is low. busy stays high until
// the response has been issued.
// Response channel: rsp_valid is high for exactly one cycle with the status,
// the data word and a snapshot of every statistic. The receiver cannot stall.
// Sequence: a lookup reads the bucket head, then walks the chain one node a
// cycle and settles the status; an add that misses, a delete that unlinks and
// a replace that writes take one more step. Null data, flush and unused kinds
// respond straight after the head read. After any kind but flush, a new
// transaction can be taken the cycle after the response; the unit takes no
// new transaction while one is in progress.
// After reset, and after a flush, a pass over the bucket head memory marks
// every bucket empty, one bucket a cycle; busy is high then.
// Node contents are undefined until written through a chain.
module integer_key_chained_hash_table_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire ikht_pkg::req_type req_data,
   output logic                 rsp_valid,
   output ikht_pkg::rsp_type    rsp_data
);
   import ikht_pkg::*;

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW = $clog2(NODES);
   localparam int LW = NW + 1;
   localparam logic [LW-1:0] NO_NODE = LW'(NODES);

   // Memories.
   logic [LW-1:0] head_mem [BUCKETS];
   logic [31:0]   key_mem  [NODES];
   logic [31:0]   data_mem [NODES];
   logic [LW-1:0] link_mem [NODES];

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [BW-1:0] bkt;
   logic [LW-1:0] cur_ff, cur_in, prev_ff, prev_in, head_rd_ff;
   logic [31:0]   nkey_ff, ndata_ff;
   logic [LW-1:0] nlink_ff;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [BW:0]   clr_ff, clr_in;
   logic          hit_ff, hit_in;
   logic [LW-1:0] free_ff, free_in, fresh_ff, fresh_in;
   logic [8:0]    entries_ff, entries_in;
   logic [31:0]   dels_ff, dels_in, looks_ff, looks_in, hits_ff, hits_in;
   logic [31:0]   cmp_ff, cmp_in;
   logic [6:0]    empty_ff, empty_in;
   logic [8:0]    worst_ff, worst_in;
   logic [2:0]    st_ff, st_in;
   logic [31:0]   dout_ff, dout_in;
   logic [LW-1:0] alloc_ff, alloc_in;
   logic [LW-1:0] fl_d_ff;

   // Head memory port controls.
   logic          hwr;
   logic [BW-1:0] hwa;
   logic [LW-1:0] hwd;
   // Node memory write controls.
   logic          kwr, lwr, dwr;
   logic [NW-1:0] nwa, lwa;
   logic [LW-1:0] lwd;
   logic [31:0]   dwd;

   assign bkt = req_ff.key[BW-1:0];

   function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // Memory accesses: one write and one registered read per memory.
   // Node reads are addressed by the next node pointer, so the node data
   // lines up with cur_ff in the following cycle.
   always_ff @(posedge clock) begin
      if (hwr) head_mem[hwa] <= hwd;
      head_rd_ff <= head_mem[bkt];
      if (kwr) begin
         key_mem[nwa] <= req_ff.key;
      end
      if (dwr) data_mem[nwa] <= dwd;
      if (lwr) link_mem[lwa] <= lwd;
      nkey_ff  <= key_mem[cur_in[NW-1:0]];
      ndata_ff <= data_mem[cur_in[NW-1:0]];
      nlink_ff <= link_mem[cur_in[NW-1:0]];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         free_ff <= NO_NODE;
         fresh_ff <= '0;
         entries_ff <= '0;
         dels_ff <= '0;
         looks_ff <= '0;
         hits_ff <= '0;
         cmp_ff <= '0;
         empty_ff <= 7'(BUCKETS);
         worst_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         free_ff <= free_in;
         fresh_ff <= fresh_in;
         entries_ff <= entries_in;
         dels_ff <= dels_in;
         looks_ff <= looks_in;
         hits_ff <= hits_in;
         cmp_ff <= cmp_in;
         empty_ff <= empty_in;
         worst_ff <= worst_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (start && !busy) req_ff <= req_data;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      cnt_ff <= cnt_in;
      hit_ff <= hit_in;
      st_ff <= st_in;
      dout_ff <= dout_in;
      alloc_ff <= alloc_in;
      // The old free head, kept for the freed node's link.
      if (state_ff == S_UNLINK) fl_d_ff <= free_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_HEAD;
         S_CLEAR: if (clr_ff == (BW+1)'(BUCKETS - 1)) state_in = S_IDLE;
         S_HEAD: begin
            unique case (req_ff.kind)
               KIND_FIND, KIND_DELETE: state_in = S_READ;
               KIND_ADD, KIND_REPLACE:
                  state_in = (req_ff.data_value == '0) ? S_DONE : S_READ;
               KIND_FLUSH: state_in = S_DONE;
               default: state_in = S_DONE;
            endcase
         end
         S_READ: state_in = (cur_in == NO_NODE) ? S_FREE : S_CMP;
         S_CMP: begin
            if (nkey_ff == req_ff.key) state_in = S_FREE;
            else if (nlink_ff >= NO_NODE || cnt_ff >= LW'(NODES - 1)) state_in = S_FREE;
            else state_in = S_CMP;
         end
         S_FREE: begin
            if (req_ff.kind == KIND_ADD && !hit_in) state_in = S_ALLOC;
            else if (req_ff.kind == KIND_DELETE && hit_in) state_in = S_UNLINK;
            else if (req_ff.kind == KIND_REPLACE && hit_in) state_in = S_REPL;
            else state_in = S_DONE;
         end
         S_ALLOC, S_UNLINK, S_REPL: state_in = S_DONE;
         S_DONE: state_in = (req_ff.kind == KIND_FLUSH) ? S_CLEAR : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      cur_in = cur_ff;
      prev_in = prev_ff;
      cnt_in = cnt_ff;
      hit_in = hit_ff;
      clr_in = clr_ff;
      free_in = free_ff;
      fresh_in = fresh_ff;
      entries_in = entries_ff;
      dels_in = dels_ff;
      looks_in = looks_ff;
      hits_in = hits_ff;
      cmp_in = cmp_ff;
      empty_in = empty_ff;
      worst_in = worst_ff;
      st_in = st_ff;
      dout_in = dout_ff;
      alloc_in = alloc_ff;
      hwr = 1'b0; hwa = bkt; hwd = NO_NODE;
      kwr = 1'b0; dwr = 1'b0; lwr = 1'b0;
      nwa = alloc_ff[NW-1:0]; lwa = alloc_ff[NW-1:0];
      lwd = NO_NODE; dwd = req_ff.data_value;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0; hit_in = 1'b0; prev_in = NO_NODE;
            st_in = ST_OK; dout_in = '0;
         end
         S_CLEAR: begin
            hwr = 1'b1; hwa = clr_ff[BW-1:0]; hwd = NO_NODE;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (BW+1)'(BUCKETS - 1)) clr_in = '0;
         end
         S_HEAD: begin
            if ((req_ff.kind == KIND_ADD || req_ff.kind == KIND_REPLACE)
                && req_ff.data_value == '0) st_in = ST_NULL_DATA;
            if (req_ff.kind == KIND_FLUSH) begin
               free_in = NO_NODE; fresh_in = '0; entries_in = '0; dels_in = '0;
               looks_in = '0; hits_in = '0; cmp_in = '0; worst_in = '0;
               empty_in = 7'(BUCKETS);
            end
         end
         S_READ: cur_in = head_rd_ff;
         S_CMP: begin
            cnt_in = cnt_ff + 1'b1;
            if (nkey_ff == req_ff.key) begin
               hit_in = 1'b1;
               dout_in = ndata_ff;
            end else begin
               prev_in = cur_ff;
               cur_in = nlink_ff;
            end
         end
         S_FREE: begin
            if (req_ff.kind == KIND_FIND || req_ff.kind == KIND_ADD) begin
               looks_in = sat_inc(looks_ff, 32'd1);
               hits_in = sat_inc(hits_ff, {31'd0, hit_ff});
               cmp_in = sat_inc(cmp_ff, 32'(cnt_ff));
               if (9'(cnt_ff) > worst_ff) worst_in = 9'(cnt_ff);
            end
            if (req_ff.kind == KIND_FIND && hit_ff) st_in = ST_OK;
            else if (req_ff.kind == KIND_ADD && hit_ff) st_in = ST_DUPLICATE;
            else if (req_ff.kind != KIND_ADD && !hit_ff) st_in = ST_NOT_FOUND;
            if (req_ff.kind != KIND_FIND && !(req_ff.kind == KIND_ADD && hit_ff))
               dout_in = '0;
            // Node for an add: free list first, then the unused pool.
            alloc_in = (free_ff != NO_NODE) ? free_ff : fresh_ff;
            if (req_ff.kind == KIND_ADD && !hit_ff && free_ff != NO_NODE)
               cur_in = free_ff;
         end
         S_ALLOC: begin
            // The free-list successor is read from link_mem at alloc_ff.
            if (free_ff == NO_NODE && fresh_ff >= LW'(NODES)) begin
               st_in = ST_POOL_FULL;
            end else begin
               if (free_ff != NO_NODE) free_in = nlink_ff;
               else fresh_in = fresh_ff + 1'b1;
               kwr = 1'b1; dwr = 1'b1; lwr = 1'b1; lwd = head_rd_ff;
               hwr = 1'b1; hwd = alloc_ff;
               if (head_rd_ff == NO_NODE && empty_ff != '0) empty_in = empty_ff - 1'b1;
               entries_in = entries_ff + 1'b1;
            end
         end
         S_UNLINK: begin
            if (prev_ff != NO_NODE) begin
               lwr = 1'b1; lwa = prev_ff[NW-1:0]; lwd = nlink_ff;
            end else begin
               hwr = 1'b1; hwd = nlink_ff;
               if (nlink_ff == NO_NODE) empty_in = empty_ff + 1'b1;
            end
            free_in = cur_ff;
            dels_in = sat_inc(dels_ff, 32'd1);
            if (entries_ff != '0) entries_in = entries_ff - 1'b1;
         end
         S_REPL: begin
            dwr = 1'b1; nwa = cur_ff[NW-1:0];
         end
         S_DONE: begin
            // The freed node links to the old free head, in the cycle after the unlink.
            if (req_ff.kind == KIND_DELETE && hit_ff) begin
               lwr = 1'b1; lwa = cur_ff[NW-1:0]; lwd = fl_d_ff;
            end
         end
         default: ;
      endcase
   end

   // Outputs.
   always_comb begin
      busy = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_DONE);
      rsp_data.status = st_ff;
      rsp_data.data_out = dout_ff;
      rsp_data.entry_count = entries_ff;
      rsp_data.delete_count = dels_ff;
      rsp_data.empty_buckets = empty_ff;
      rsp_data.scan_count = looks_ff;
      rsp_data.hit_count = hits_ff;
      rsp_data.check_count = cmp_ff;
      rsp_data.longest_scan = worst_ff;
   end

   a_resp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double response");
   a_hits: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= looks_ff) else $error("hits exceed lookups");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");
endmodule
`default_nettype wire

FILE: bench/ikht_checker.sv
module ikht_checker
   import ikht_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     start,
   input  wire     busy,
   input  req_type req_data,
   input  wire     rsp_valid,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUCKETS = 64;
   localparam int NODES = 256;
   localparam logic [8:0] NIL = 9'(NODES);

   // Shadow copy of the table and its statistics.
   logic [8:0]  head_of[BUCKETS];
   logic [31:0] key_of[NODES];
   logic [31:0] data_of[NODES];
   logic [8:0]  link_of[NODES];
   logic [8:0]  free_list;
   logic [8:0]  fresh_used;
   logic [8:0]  entries;
   logic [31:0] deletions;
   logic [6:0]  empties;
   logic [31:0] lookups;
   logic [31:0] hits;
   logic [31:0] compared;
   logic [8:0]  worst_scan;

   rsp_type expected_rsp[$];

   assign pending = expected_rsp.size();

   function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   task automatic empty_table();
      for (int i = 0; i < BUCKETS; i++) head_of[i] = NIL;
      free_list = NIL;
      fresh_used = '0;
      entries = '0;
      deletions = '0;
      empties = 7'(BUCKETS);
      lookups = '0;
      hits = '0;
      compared = '0;
      worst_scan = '0;
   endtask

   // Walk one chain; returns matching node or NIL, with predecessor and count.
   task automatic walk_chain(input logic [5:0] b, input logic [31:0] k,
                             output logic [8:0] hit, output logic [8:0] prev,
                             output logic [8:0] count);
      logic [8:0] n;
      n = head_of[b];
      prev = NIL;
      count = '0;
      hit = NIL;
      while (n != NIL && count < NODES) begin
         count++;
         if (key_of[n] == k) begin
            hit = n;
            return;
         end
         prev = n;
         n = link_of[n];
      end
   endtask

   task automatic counted_lookup(input logic [5:0] b, input logic [31:0] k,
                                 output logic [8:0] hit);
      logic [8:0] prev, count;
      walk_chain(b, k, hit, prev, count);
      lookups = sat_inc(lookups, 1);
      if (hit != NIL) hits = sat_inc(hits, 1);
      if (count > worst_scan) worst_scan = count;
      compared = sat_inc(compared, 32'(count));
   endtask

   // Apply one operation to the shadow table and return the expected response.
   task automatic apply_operation(input req_type r, output rsp_type e);
      logic [5:0]  b;
      logic [8:0]  n, prev, count, fresh;
      logic [31:0] k;
      k = r.key;
      b = k[5:0];
      e = '0;
      e.status = ST_OK;
      case (r.kind)
         KIND_FIND: begin
            counted_lookup(b, k, n);
            if (n != NIL) e.data_out = data_of[n];
            else e.status = ST_NOT_FOUND;
         end
         KIND_ADD: begin
            if (r.data_value == 0) e.status = ST_NULL_DATA;
            else begin
               counted_lookup(b, k, n);
               if (n != NIL) begin
                  e.status = ST_DUPLICATE;
                  e.data_out = data_of[n];
               end else begin
                  fresh = NIL;
                  if (free_list != NIL) begin
                     fresh = free_list;
                     free_list = link_of[fresh];
                  end else if (fresh_used < NODES) begin
                     fresh = fresh_used;
                     fresh_used++;
                  end
                  if (fresh == NIL) e.status = ST_POOL_FULL;
                  else begin
                     if (head_of[b] == NIL && empties > 0) empties--;
                     key_of[fresh] = k;
                     data_of[fresh] = r.data_value;
                     link_of[fresh] = head_of[b];
                     head_of[b] = fresh;
                     entries++;
                  end
               end
            end
         end
         KIND_DELETE: begin
            walk_chain(b, k, n, prev, count);
            if (n != NIL) begin
               if (prev != NIL) link_of[prev] = link_of[n];
               else head_of[b] = link_of[n];
               link_of[n] = free_list;
               free_list = n;
               deletions = sat_inc(deletions, 1);
               if (entries > 0) entries--;
               if (head_of[b] == NIL) empties++;
            end else e.status = ST_NOT_FOUND;
         end
         KIND_REPLACE: begin
            if (r.data_value == 0) e.status = ST_NULL_DATA;
            else begin
               walk_chain(b, k, n, prev, count);
               if (n != NIL) data_of[n] = r.data_value;
               else e.status = ST_NOT_FOUND;
            end
         end
         KIND_FLUSH: empty_table();
         default: ;
      endcase
      e.entry_count = entries;
      e.delete_count = deletions;
      e.empty_buckets = empties;
      e.scan_count = lookups;
      e.hit_count = hits;
      e.check_count = compared;
      e.longest_scan = worst_scan;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      empty_table();
   end

   // Predict on each accepted request, compare each response transaction.
   always @(posedge clock) begin
      rsp_type e, got;
      if (!reset) begin
         if (start && !busy) begin
            apply_operation(req_data, e);
            expected_rsp.push_back(e);
         end
         if (rsp_valid) begin
            got = rsp_data;
            if (expected_rsp.size() == 0) begin
               $display("%0t: response with no request outstanding", $realtime);
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (got.status !== e.status) report_mismatch("status", got.status, e.status);
               if (got.data_out !== e.data_out)
                  report_mismatch("data_out", got.data_out, e.data_out);
               if (got.entry_count !== e.entry_count)
                  report_mismatch("entry_count", got.entry_count, e.entry_count);
               if (got.delete_count !== e.delete_count)
                  report_mismatch("delete_count", got.delete_count, e.delete_count);
               if (got.empty_buckets !== e.empty_buckets)
                  report_mismatch("empty_buckets", got.empty_buckets, e.empty_buckets);
               if (got.scan_count !== e.scan_count)
                  report_mismatch("scan_count", got.scan_count, e.scan_count);
               if (got.hit_count !== e.hit_count)
                  report_mismatch("hit_count", got.hit_count, e.hit_count);
               if (got.check_count !== e.check_count)
                  report_mismatch("check_count", got.check_count, e.check_count);
               if (got.longest_scan !== e.longest_scan)
                  report_mismatch("longest_scan", got.longest_scan, e.longest_scan);
            end
         end
      end
   end
endmodule

FILE: bench/tb_integer_key_chained_hash_table_unit.sv
module tb_integer_key_chained_hash_table_unit;
   import ikht_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   wire     busy;
   wire     rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      quiet_cycles = 0;
   bit      calm = 1'b0;

   logic [31:0] key_pool[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   integer_key_chained_hash_table_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   ikht_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending(pending)
   );

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("integer_key_chained_hash_table_unit test failed");
         $finish;
      end
   end

   // Present one request and hold it, with random gaps, until busy is seen low.
   // start is left high on return so that the next request can follow at once.
   task automatic send(input logic [2:0] kind, input logic [31:0] key,
                       input logic [31:0] value);
      while (!calm && $urandom_range(99) < 9) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{kind: kind, key: key, data_value: value};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Keys mostly from a small set so that chains grow and hits are common.
   function automatic logic [31:0] pick_key();
      logic [31:0] k;
      if (key_pool.size() > 0 && $urandom_range(99) < 70)
         return key_pool[$urandom_range(key_pool.size() - 1)];
      case ($urandom_range(3))
         0: k = $urandom;
         1: k = {2'($urandom_range(3)), 24'h0, 6'($urandom_range(3))};
         default: k = {($urandom & 32'hFFFF_FF00) | $urandom_range(255)} & 32'hC000_003F;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] k;
      logic [2:0]  kind;
      int          r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extremes, every status code but pool full.
      send(KIND_FIND, 32'h8000_0000, 32'h0);
      send(KIND_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
      send(KIND_ADD, 32'h7FFF_FFFF, 32'h1);
      send(KIND_ADD, 32'h0000_0000, 32'h0);
      send(KIND_ADD, 32'h8000_0000, 32'h1234_5678);
      send(KIND_ADD, 32'h0000_0040, 32'hA5A5_A5A5);
      send(KIND_ADD, 32'hFFFF_FFC0, 32'h5A5A_5A5A);
      send(KIND_FIND, 32'h8000_0000, 32'h0);
      send(KIND_FIND, 32'h0000_0080, 32'h0);
      send(KIND_REPLACE, 32'h0000_0040, 32'h0);
      send(KIND_REPLACE, 32'h0000_0040, 32'hDEAD_BEEF);
      send(KIND_REPLACE, 32'h0000_0100, 32'h1);
      send(KIND_DELETE, 32'h0000_0040, 32'h0);
      send(KIND_DELETE, 32'h0000_0040, 32'h0);
      send(KIND_FIND, 32'hFFFF_FFC0, 32'hFFFF_FFFF);
      send(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(3'd7, 32'h0, 32'h0);
      send(KIND_FLUSH, 32'h0, 32'h0);
      send(KIND_FIND, 32'h8000_0000, 32'h0);

      // Fill the pool past its size to reach pool full, then empty it.
      for (int i = 0; i < 260; i++) send(KIND_ADD, i * 7, i + 1);
      for (int i = 0; i < 40; i++) send(KIND_DELETE, i * 7, 0);
      for (int i = 0; i < 42; i++) send(KIND_ADD, 32'h1000_0000 + i, 32'hFFFF_FFFF);
      send(KIND_FLUSH, 32'h0, 32'h0);

      // Random mix, with a calm stretch free of gaps.
      for (int i = 0; i < 1400; i++) begin
         calm = (i >= 500 && i < 700);
         if (key_pool.size() < 48 && $urandom_range(3) == 0) key_pool.push_back($urandom);
         if ($urandom_range(6) == 0) key_pool.push_back({4'($urandom_range(15)), 22'h0,
                                                          6'($urandom_range(1))});
         k = pick_key();
         r = $urandom_range(99);
         if (r < 30) kind = KIND_FIND;
         else if (r < 62) kind = KIND_ADD;
         else if (r < 80) kind = KIND_DELETE;
         else if (r < 95) kind = KIND_REPLACE;
         else if (r < 97) kind = KIND_FLUSH;
         else kind = 3'($urandom_range(7));
         send(kind, k, pick_value());
         if (key_pool.size() > 64) key_pool.delete(0);
      end
      calm = 1'b0;
      start <= 1'b0;

      // Drain and allow a short settle time.
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("integer_key_chained_hash_table_unit test passed");
      end else begin
         $display("integer_key_chained_hash_table_unit test failed");
      end
      $finish;
   end
endmodule
